// File: design/gzcb_pkg.sv
// gzcb_pkg: shared constants, register codes and helper functions for the
// grid zero crossing bracket block; no dependencies
package gzcb_pkg;

    localparam int DataWidth  = 32;
    localparam int MaxPoints  = 1024;
    localparam int CountWidth = 11;
    localparam int ProdWidth  = 45;   // signed grid index times interval width
    localparam int DivSteps   = 44;   // magnitude bits of the product
    localparam int CntWidth   = 6;

    // register indexes
    localparam logic [2:0] RegPrecision  = 3'd0;
    localparam logic [2:0] RegRunLimit   = 3'd1;
    localparam logic [2:0] RegRangeStart = 3'd2;
    localparam logic [2:0] RegRangeEnd   = 3'd3;
    localparam logic [2:0] RegPointCount = 3'd4;

    // result kinds and finish codes
    localparam logic       KindRequest    = 1'b0;
    localparam logic       KindFinal      = 1'b1;
    localparam logic       OpStart        = 1'b0;
    localparam logic [1:0] StPrecision    = 2'd0;
    localparam logic [1:0] StEndsMet      = 2'd1;
    localparam logic [1:0] StRunsUsed     = 2'd2;
    localparam logic [1:0] StNoneFound    = 2'd3;

    function automatic logic [DataWidth-1:0] magnitude(input logic signed [DataWidth-1:0] v);
        magnitude = v[DataWidth-1] ? (~v + 1'b1) : v;
    endfunction

    // saturating multiply by ten of a 33 bit value
    function automatic logic [DataWidth-1:0] times_ten(input logic signed [DataWidth:0] v);
        logic signed [DataWidth:0] prod;
        prod = (v <<< 3) + (v <<< 1);
        if (v > 33'sd214748364)
            times_ten = 32'h7fff_ffff;
        else if (v < -33'sd214748364)
            times_ten = 32'h8000_0000;
        else
            times_ten = prod[DataWidth-1:0];
    endfunction

endpackage

// File: design/grid_zero_crossing_bracket.sv
// grid_zero_crossing_bracket: top level of the root bracketing grid search
// depends on gzcb_pkg for constants, register codes and helper functions
//
// A start request loads the interval from range_start and range_end and the
// block asks for f at each of n+1 evenly spaced points (n is point_count
// clamped to 1..1024), one request result per point; each returned value
// request is folded into the nearest non-positive and non-negative samples.
// A run ends on a sign change or after the last point, then the interval is
// narrowed to the bracket or, if none, ordered, made to straddle zero and
// widened tenfold with saturation. The final result reports the sample closer
// to zero. Each grid point's request is computed as low + i*(high-low)/n,
// and the division by n runs one quotient bit per cycle on a shared
// restoring divider (44 steps) between a load state and the issue of the
// point request. A start request first passes through the set-up state.
// At the end of a run the narrowing, stop-test and set-up states come before
// the next run's first point request, and the final result is registered
// from the stop-test state after the narrowing state. Input is taken only
// while the block waits for a request and no result is pending.
module grid_zero_crossing_bracket
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic signed [31:0] function_value,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic signed [31:0] sample_x,
    output logic signed [31:0] sample_f,
    output logic [1:0]  finish_status
);

    localparam int DW = gzcb_pkg::DataWidth;
    localparam int CW = gzcb_pkg::CountWidth;
    localparam int PW = gzcb_pkg::ProdWidth;
    localparam int QW = gzcb_pkg::DivSteps;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // no search active
    localparam logic [2:0] S_WAIT = 3'd1;  // waiting for a function value
    localparam logic [2:0] S_PREP = 3'd2;  // set up a new run
    localparam logic [2:0] S_LOAD = 3'd3;  // load divider
    localparam logic [2:0] S_DIV  = 3'd4;  // one quotient bit per cycle
    localparam logic [2:0] S_ER1  = 3'd5;  // narrow or widen the interval
    localparam logic [2:0] S_ER2  = 3'd6;  // stop tests

    // configuration registers
    logic [30:0]          prec_reg;
    logic [7:0]           run_limit_reg;
    logic signed [DW-1:0] range_start_reg;
    logic signed [DW-1:0] range_end_reg;
    logic [CW-1:0]        point_count_reg;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg        <= 31'd66;
            run_limit_reg   <= 8'd10;
            range_start_reg <= -32'sd65536;
            range_end_reg   <= 32'sd65536;
            point_count_reg <= 11'd100;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                gzcb_pkg::RegPrecision:  prec_reg        <= pwdata[30:0];
                gzcb_pkg::RegRunLimit:   run_limit_reg   <= pwdata[7:0];
                gzcb_pkg::RegRangeStart: range_start_reg <= pwdata;
                gzcb_pkg::RegRangeEnd:   range_end_reg   <= pwdata;
                gzcb_pkg::RegPointCount: point_count_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            gzcb_pkg::RegPrecision:  prdata = {1'b0, prec_reg};
            gzcb_pkg::RegRunLimit:   prdata = {24'd0, run_limit_reg};
            gzcb_pkg::RegRangeStart: prdata = range_start_reg;
            gzcb_pkg::RegRangeEnd:   prdata = range_end_reg;
            gzcb_pkg::RegPointCount: prdata = {21'd0, point_count_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // effective step count, clamped to 1..max
    logic [CW-1:0] steps;
    always_comb
    begin
        if (point_count_reg == '0)
            steps = CW'(1);
        else if (point_count_reg > CW'(gzcb_pkg::MaxPoints))
            steps = CW'(gzcb_pkg::MaxPoints);
        else
            steps = point_count_reg;
    end

    // search state
    logic [2:0]           state_reg, state_next;
    logic signed [DW-1:0] low_reg, low_next;
    logic signed [DW-1:0] high_reg, high_next;
    logic [CW-1:0]        grid_reg, grid_next;
    logic [7:0]           run_reg, run_next;
    logic signed [DW-1:0] cur_x_reg, cur_x_next;
    logic signed [DW-1:0] prev_f_reg, prev_f_next;
    logic                 neg_found_reg, neg_found_next;
    logic signed [DW-1:0] neg_x_reg, neg_x_next, neg_f_reg, neg_f_next;
    logic                 pos_found_reg, pos_found_next;
    logic signed [DW-1:0] pos_x_reg, pos_x_next, pos_f_reg, pos_f_next;
    // running product grid index times interval width, and divider
    logic signed [DW:0]   diff_reg, diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [QW-1:0]        dvd_reg, dvd_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [gzcb_pkg::CntWidth-1:0] cnt_reg, cnt_next;
    logic                 qneg_reg, qneg_next;
    // output register
    logic                 ov_reg, ov_next;
    logic                 kind_reg, kind_next;
    logic signed [DW-1:0] ox_reg, ox_next, of_reg, of_next;
    logic [1:0]           ost_reg, ost_next;

    assign in_ready      = ((state_reg == S_IDLE) || (state_reg == S_WAIT)) && !ov_reg;
    assign out_valid     = ov_reg;
    assign result_kind   = kind_reg;
    assign sample_x      = ox_reg;
    assign sample_f      = of_reg;
    assign finish_status = ost_reg;

    logic in_acc;
    assign in_acc = in_valid & in_ready;

    // divider step
    logic [CW:0]   rem_try;
    logic          q_bit;
    logic [CW:0]   rem_sub;
    assign rem_try = {rem_reg, dvd_reg[QW-1]};
    assign q_bit   = rem_try >= {1'b0, steps};
    assign rem_sub = rem_try - {1'b0, steps};

    logic [DW-1:0] quot_s;
    assign quot_s = qneg_reg ? (~dvd_reg[DW-1:0] + 1'b1) : dvd_reg[DW-1:0];

    // sample update for a returned value
    logic signed [DW-1:0] fx;
    logic neg_upd, pos_upd, crossed;
    assign fx      = function_value;
    assign neg_upd = (fx <= 0) && (!neg_found_reg || fx > neg_f_reg);
    assign pos_upd = (fx >= 0) && (!pos_found_reg || fx < pos_f_reg);
    assign crossed = (grid_reg != '0) &&
                     (((prev_f_reg > 0) && (fx <= 0)) || ((prev_f_reg < 0) && (fx >= 0)));

    // interval widening when no bracket was found
    logic signed [DW-1:0] ord_lo, ord_hi;
    logic signed [DW:0]   str_lo, str_hi;
    always_comb
    begin
        ord_lo = (low_reg > high_reg) ? high_reg : low_reg;
        ord_hi = (low_reg > high_reg) ? low_reg : high_reg;
        str_lo = (ord_lo > 0) ? -(DW+1)'(ord_lo) : (DW+1)'(ord_lo);
        str_hi = (ord_hi < 0) ? -(DW+1)'(ord_hi) : (DW+1)'(ord_hi);
    end

    // stop tests and final choice
    logic [DW-1:0] neg_mag, pos_mag;
    logic          prec_hit, pick_neg;
    assign neg_mag  = gzcb_pkg::magnitude(neg_f_reg);
    assign pos_mag  = gzcb_pkg::magnitude(pos_f_reg);
    assign prec_hit = (neg_found_reg && (neg_mag < {1'b0, prec_reg})) ||
                      (pos_found_reg && (pos_mag < {1'b0, prec_reg}));
    assign pick_neg = neg_found_reg && (!pos_found_reg || neg_mag < pos_mag);

    logic [7:0] run_inc;
    assign run_inc = run_reg + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        grid_next      = grid_reg;
        run_next       = run_reg;
        cur_x_next     = cur_x_reg;
        prev_f_next    = prev_f_reg;
        neg_found_next = neg_found_reg;
        neg_x_next     = neg_x_reg;
        neg_f_next     = neg_f_reg;
        pos_found_next = pos_found_reg;
        pos_x_next     = pos_x_reg;
        pos_f_next     = pos_f_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        qneg_next      = qneg_reg;
        ov_next        = ov_reg && !out_ready;
        kind_next      = kind_reg;
        ox_next        = ox_reg;
        of_next        = of_reg;
        ost_next       = ost_reg;

        if (in_acc && operation == gzcb_pkg::OpStart)
        begin
            // start request, abandons any active search
            low_next       = range_start_reg;
            high_next      = range_end_reg;
            run_next       = 8'd0;
            neg_found_next = 1'b0;
            pos_found_next = 1'b0;
            neg_x_next     = '0;
            neg_f_next     = '0;
            pos_x_next     = '0;
            pos_f_next     = '0;
            if (run_limit_reg == 8'd0)
            begin
                ov_next    = 1'b1;
                kind_next  = gzcb_pkg::KindFinal;
                ox_next    = '0;
                of_next    = '0;
                ost_next   = gzcb_pkg::StNoneFound;
                state_next = S_IDLE;
            end
            else
                state_next = S_PREP;
        end
        else
        begin
            case (state_reg)
                S_IDLE: ;
                S_WAIT:
                begin
                    if (in_acc)
                    begin
                        if (neg_upd)
                        begin
                            neg_found_next = 1'b1;
                            neg_f_next     = fx;
                            neg_x_next     = cur_x_reg;
                        end
                        if (pos_upd)
                        begin
                            pos_found_next = 1'b1;
                            pos_f_next     = fx;
                            pos_x_next     = cur_x_reg;
                        end
                        prev_f_next = fx;
                        if (crossed || grid_reg >= steps)
                            state_next = S_ER1;
                        else
                        begin
                            grid_next  = grid_reg + CW'(1);
                            prod_next  = prod_reg + PW'(diff_reg);
                            state_next = S_LOAD;
                        end
                    end
                end
                S_PREP:
                begin
                    grid_next      = '0;
                    neg_found_next = 1'b0;
                    pos_found_next = 1'b0;
                    neg_x_next     = '0;
                    neg_f_next     = '0;
                    pos_x_next     = '0;
                    pos_f_next     = '0;
                    prev_f_next    = '0;
                    diff_next      = (DW+1)'(high_reg) - (DW+1)'(low_reg);
                    prod_next      = '0;
                    state_next     = S_LOAD;
                end
                S_LOAD:
                begin
                    qneg_next  = prod_reg[PW-1];
                    dvd_next   = prod_reg[PW-1] ? QW'(-prod_reg) : QW'(prod_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == gzcb_pkg::CntWidth'(QW))
                    begin
                        // quotient complete, issue the point request
                        cur_x_next = low_reg + quot_s;
                        ov_next    = 1'b1;
                        kind_next  = gzcb_pkg::KindRequest;
                        ox_next    = low_reg + quot_s;
                        of_next    = '0;
                        ost_next   = gzcb_pkg::StPrecision;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        rem_next = q_bit ? rem_sub[CW-1:0] : rem_try[CW-1:0];
                        dvd_next = {dvd_reg[QW-2:0], q_bit};
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                S_ER1:
                begin
                    if (neg_found_reg && pos_found_reg)
                    begin
                        low_next  = neg_x_reg;
                        high_next = pos_x_reg;
                    end
                    else
                    begin
                        low_next  = gzcb_pkg::times_ten(str_lo);
                        high_next = gzcb_pkg::times_ten(str_hi);
                    end
                    state_next = S_ER2;
                end
                S_ER2:
                begin
                    kind_next = gzcb_pkg::KindFinal;
                    ox_next   = pick_neg ? neg_x_reg : pos_x_reg;
                    of_next   = pick_neg ? neg_f_reg : pos_f_reg;
                    if (low_reg == high_reg)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = gzcb_pkg::StEndsMet;
                        state_next = S_IDLE;
                    end
                    else if (prec_hit)
                    begin
                        ov_next    = 1'b1;
                        ost_next   = gzcb_pkg::StPrecision;
                        state_next = S_IDLE;
                    end
                    else if (run_inc >= run_limit_reg)
                    begin
                        run_next   = run_inc;
                        ov_next    = 1'b1;
                        ost_next   = gzcb_pkg::StRunsUsed;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        run_next   = run_inc;
                        state_next = S_PREP;
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ov_reg        <= 1'b0;
            neg_found_reg <= 1'b0;
            pos_found_reg <= 1'b0;
            grid_reg      <= '0;
            run_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ov_reg        <= ov_next;
            neg_found_reg <= neg_found_next;
            pos_found_reg <= pos_found_next;
            grid_reg      <= grid_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        low_reg    <= low_next;
        high_reg   <= high_next;
        cur_x_reg  <= cur_x_next;
        prev_f_reg <= prev_f_next;
        neg_x_reg  <= neg_x_next;
        neg_f_reg  <= neg_f_next;
        pos_x_reg  <= pos_x_next;
        pos_f_reg  <= pos_f_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        qneg_reg   <= qneg_next;
        kind_reg   <= kind_next;
        ox_reg     <= ox_next;
        of_reg     <= of_next;
        ost_reg    <= ost_next;
    end

endmodule
